/* hdl/pcfs_pkg.sv */
`default_nettype none

package pcfs_pkg;

  localparam int MaxEntries = 32;
  localparam logic [7:0] Pdu2Threshold = 8'd240;
  localparam logic [3:0] MaxDlc = 4'd8;

  typedef enum logic [1:0] {
    FUNC_ADD  = 2'd0,
    FUNC_TICK = 2'd1,
    FUNC_SEND = 2'd2
  } func_e;

  // one classified word handed from front to back
  typedef struct packed {
    func_e        op;
    logic [17:0]  pgn;
    logic [2:0]   prio;
    logic [7:0]   sa;
    logic [31:0]  period;
    logic [3:0]   len;
    logic [63:0]  payload;
    logic [31:0]  last_sent;
    logic [31:0]  now;
  } cmd_t;

  // static part of a table entry; last-sent time lives in its own memory
  typedef struct packed {
    logic [17:0]  pgn;
    logic [2:0]   prio;
    logic [7:0]   sa;
    logic [31:0]  period;
    logic [3:0]   len;
    logic [63:0]  payload;
  } entry_t;

endpackage

`default_nettype wire

/* hdl/periodic_can_frame_scheduler.sv */
`default_nettype none

// Periodic J1939 frame scheduler. A word is taken when start_i is high and
// busy_o is low; a two-word queue sits in front of the table engine, so busy_o
// rises only when that queue is full. A tick or a send walks the table at one
// entry per cycle through the entry memory; a send stops at its first match.
// Each frame appears for one cycle with frame_valid_o; the receiver cannot stall,
// and frames of one word come out in table order with last_frame_o set on the
// final one. No frame is made from an entry evaluated while transmit_enable
// (cfg_wdata_i written with cfg_we_i) is 0.
module periodic_can_frame_scheduler #(
  parameter int MAX_ENTRIES = pcfs_pkg::MaxEntries
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_wdata_i,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire logic [1:0]       func_i,
  input  wire logic [17:0]      pgn_i,
  input  wire logic [2:0]       priority_req_i,
  input  wire logic [7:0]       source_address_i,
  input  wire logic [31:0]      period_ms_i,
  input  wire logic [3:0]       data_length_i,
  input  wire logic [63:0]      payload_i,
  input  wire logic [31:0]      last_sent_ms_i,
  input  wire logic [31:0]      now_ms_i,
  output logic                  frame_valid_o,
  output logic [28:0]           can_id_o,
  output logic [3:0]            dlc_o,
  output logic [63:0]           frame_data_o,
  output logic                  last_frame_o
);

  logic           tx_en_q;
  logic           q_vld;
  logic           pop;
  pcfs_pkg::cmd_t q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      tx_en_q <= cfg_wdata_i;
    end
  end

  pcfs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .func_i           (func_i),
    .pgn_i            (pgn_i),
    .priority_req_i   (priority_req_i),
    .source_address_i (source_address_i),
    .period_ms_i      (period_ms_i),
    .data_length_i    (data_length_i),
    .payload_i        (payload_i),
    .last_sent_ms_i   (last_sent_ms_i),
    .now_ms_i         (now_ms_i),
    .q_vld_o          (q_vld),
    .q_cmd_o          (q_cmd),
    .pop_i            (pop)
  );

  pcfs_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tx_en_i       (tx_en_q),
    .q_vld_i       (q_vld),
    .q_cmd_i       (q_cmd),
    .pop_o         (pop),
    .frame_valid_o (frame_valid_o),
    .can_id_o      (can_id_o),
    .dlc_o         (dlc_o),
    .frame_data_o  (frame_data_o),
    .last_frame_o  (last_frame_o)
  );

endmodule

`default_nettype wire

/* hdl/pcfs_front.sv */
`default_nettype none

module pcfs_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire logic [1:0]       func_i,
  input  wire logic [17:0]      pgn_i,
  input  wire logic [2:0]       priority_req_i,
  input  wire logic [7:0]       source_address_i,
  input  wire logic [31:0]      period_ms_i,
  input  wire logic [3:0]       data_length_i,
  input  wire logic [63:0]      payload_i,
  input  wire logic [31:0]      last_sent_ms_i,
  input  wire logic [31:0]      now_ms_i,
  output logic                  q_vld_o,
  output pcfs_pkg::cmd_t        q_cmd_o,
  input  wire logic             pop_i
);

  pcfs_pkg::cmd_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           known;
  logic           push;
  pcfs_pkg::cmd_t cmd;

  always_comb begin
    unique case (pcfs_pkg::func_e'(func_i))
      pcfs_pkg::FUNC_ADD,
      pcfs_pkg::FUNC_TICK,
      pcfs_pkg::FUNC_SEND: known = 1'b1;
      default:             known = 1'b0; // unused code is dropped here
    endcase
  end

  always_comb begin
    cmd.op        = pcfs_pkg::func_e'(func_i);
    cmd.pgn       = pgn_i;
    cmd.prio      = priority_req_i;
    cmd.sa        = source_address_i;
    cmd.period    = period_ms_i;
    cmd.len       = data_length_i;
    cmd.payload   = payload_i;
    cmd.last_sent = last_sent_ms_i;
    cmd.now       = now_ms_i;
  end

  assign busy_o  = (cnt_q == 2'd2);
  assign push    = start_i && !busy_o && known;
  assign q_vld_o = (cnt_q != 2'd0);
  assign q_cmd_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= cmd;
  end

endmodule

`default_nettype wire

/* hdl/pcfs_back.sv */
`default_nettype none

module pcfs_back #(
  parameter int MAX_ENTRIES = pcfs_pkg::MaxEntries
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             tx_en_i,
  input  wire logic             q_vld_i,
  input  wire pcfs_pkg::cmd_t   q_cmd_i,
  output logic                  pop_o,
  output logic                  frame_valid_o,
  output logic [28:0]           can_id_o,
  output logic [3:0]            dlc_o,
  output logic [63:0]           frame_data_o,
  output logic                  last_frame_o
);

  localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CntW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        rd_idx_q, rd_idx_d;
  logic [31:0]            cur_time_q, cur_time_d;
  logic [17:0]            key_q, key_d;
  logic                   is_tick_q, is_tick_d;
  logic                   stop_q, stop_d;
  logic                   ev_vld_q, ev_vld_d;
  logic [IdxW-1:0]        ev_idx_q, ev_idx_d;

  pcfs_pkg::entry_t       ent_mem [MAX_ENTRIES];
  logic [31:0]            ls_mem  [MAX_ENTRIES];
  pcfs_pkg::entry_t       ent_rd_q;
  logic [31:0]            ls_rd_q;

  logic                   ent_we;
  pcfs_pkg::entry_t       ent_wdata;
  logic                   ls_we;
  logic [IdxW-1:0]        ls_waddr;
  logic [31:0]            ls_wdata;
  logic                   issue;

  logic                   pend_vld_q, pend_vld_d;
  logic [28:0]            pend_id_q, pend_id_d;
  logic [3:0]             pend_dlc_q, pend_dlc_d;
  logic [63:0]            pend_data_q, pend_data_d;
  logic                   out_vld_q, out_vld_d;
  logic [28:0]            out_id_q, out_id_d;
  logic [3:0]             out_dlc_q, out_dlc_d;
  logic [63:0]            out_data_q, out_data_d;
  logic                   out_last_q, out_last_d;

  logic [31:0]            elapsed;
  logic                   hit, eval_act, emit;
  logic [7:0]             pf, ps;
  logic [28:0]            new_id;
  logic [63:0]            new_data;

  // evaluation of the entry read in the previous cycle
  assign elapsed  = cur_time_q - ls_rd_q;
  assign hit      = is_tick_q ? (elapsed >= ent_rd_q.period) : (ent_rd_q.pgn == key_q);
  assign eval_act = (state_q == ST_WALK) && ev_vld_q && !stop_q;
  assign emit     = eval_act && hit && tx_en_i && (ent_rd_q.len <= pcfs_pkg::MaxDlc);
  assign pf       = ent_rd_q.pgn[15:8];
  assign ps       = (pf >= pcfs_pkg::Pdu2Threshold) ? ent_rd_q.pgn[7:0] : ent_rd_q.sa;
  assign new_id   = {ent_rd_q.prio, 2'b00, pf, ps, ent_rd_q.sa};

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      new_data[8*b +: 8] = (4'(b) < ent_rd_q.len) ? ent_rd_q.payload[8*b +: 8] : 8'h00;
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    cur_time_d = cur_time_q;
    key_d      = key_q;
    is_tick_d  = is_tick_q;
    stop_d     = stop_q;
    ev_vld_d   = 1'b0;
    ev_idx_d   = ev_idx_q;
    pop_o      = 1'b0;
    issue      = 1'b0;
    ent_we     = 1'b0;
    ent_wdata  = '{pgn: q_cmd_i.pgn, prio: q_cmd_i.prio, sa: q_cmd_i.sa,
                   period: q_cmd_i.period, len: q_cmd_i.len, payload: q_cmd_i.payload};
    ls_we      = 1'b0;
    ls_waddr   = count_q[IdxW-1:0];
    ls_wdata   = q_cmd_i.last_sent;

    unique case (state_q)
      ST_IDLE: begin
        if (q_vld_i) begin
          pop_o    = 1'b1;
          rd_idx_d = '0;
          stop_d   = 1'b0;
          case (q_cmd_i.op)
            pcfs_pkg::FUNC_ADD: begin
              if (count_q < CntW'(MAX_ENTRIES)) begin
                ent_we  = 1'b1;
                ls_we   = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            pcfs_pkg::FUNC_TICK: begin
              cur_time_d = q_cmd_i.now;
              is_tick_d  = 1'b1;
              state_d    = ST_WALK;
            end
            default: begin
              key_d     = q_cmd_i.pgn;
              is_tick_d = 1'b0;
              state_d   = ST_WALK;
            end
          endcase
        end
      end
      ST_WALK: begin
        issue    = (rd_idx_q < count_q) && !stop_q;
        ev_vld_d = issue;
        ev_idx_d = rd_idx_q[IdxW-1:0];
        if (issue) rd_idx_d = rd_idx_q + 1'b1;
        if (eval_act && hit) begin
          ls_we    = 1'b1;
          ls_waddr = ev_idx_q;
          ls_wdata = cur_time_q;
          if (!is_tick_q) stop_d = 1'b1;  // send stops at first match
        end
        if (stop_q || (!issue && !ev_vld_q)) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // one frame is held back so the final one of an item can be flagged
  always_comb begin
    pend_vld_d  = pend_vld_q;
    pend_id_d   = pend_id_q;
    pend_dlc_d  = pend_dlc_q;
    pend_data_d = pend_data_q;
    out_vld_d   = 1'b0;
    out_id_d    = pend_id_q;
    out_dlc_d   = pend_dlc_q;
    out_data_d  = pend_data_q;
    out_last_d  = 1'b0;
    if (emit) begin
      out_vld_d   = pend_vld_q;
      pend_vld_d  = 1'b1;
      pend_id_d   = new_id;
      pend_dlc_d  = ent_rd_q.len;
      pend_data_d = new_data;
    end else if (state_q == ST_FLUSH) begin
      out_vld_d  = pend_vld_q;
      out_last_d = 1'b1;
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      rd_idx_q   <= '0;
      cur_time_q <= '0;
      key_q      <= '0;
      is_tick_q  <= 1'b0;
      stop_q     <= 1'b0;
      ev_vld_q   <= 1'b0;
      ev_idx_q   <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rd_idx_q   <= rd_idx_d;
      cur_time_q <= cur_time_d;
      key_q      <= key_d;
      is_tick_q  <= is_tick_d;
      stop_q     <= stop_d;
      ev_vld_q   <= ev_vld_d;
      ev_idx_q   <= ev_idx_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q   <= pend_id_d;
    pend_dlc_q  <= pend_dlc_d;
    pend_data_q <= pend_data_d;
    out_id_q    <= out_id_d;
    out_dlc_q   <= out_dlc_d;
    out_data_q  <= out_data_d;
    out_last_q  <= out_last_d;
  end

  // entry table: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[count_q[IdxW-1:0]] <= ent_wdata;
    if (issue) ent_rd_q <= ent_mem[rd_idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ls_we) ls_mem[ls_waddr] <= ls_wdata;
    if (issue) ls_rd_q <= ls_mem[rd_idx_q[IdxW-1:0]];
  end

  assign frame_valid_o = out_vld_q;
  assign can_id_o      = out_id_q;
  assign dlc_o         = out_dlc_q;
  assign frame_data_o  = out_data_q;
  assign last_frame_o  = out_last_q;

endmodule

`default_nettype wire

/* hdl/pcfs_checker.sv */
`default_nettype none

module pcfs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        frame_valid_o,
  input wire logic [28:0] can_id_o,
  input wire logic [3:0]  dlc_o,
  input wire logic [63:0] frame_data_o
);

  a_dlc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o |-> (dlc_o <= pcfs_pkg::MaxDlc))
    else $error("frame with dlc above eight");

  a_id_reserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_valid_o |-> (can_id_o[25:24] == 2'b00))
    else $error("reserved/data page bits set");

  // PDU1 frames carry the source address as PDU specific
  a_pdu1_ps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid_o && (can_id_o[23:16] < pcfs_pkg::Pdu2Threshold))
      |-> (can_id_o[15:8] == can_id_o[7:0]))
    else $error("PDU1 specific byte is not the source address");

  a_data_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_valid_o && (dlc_o < pcfs_pkg::MaxDlc))
      |-> ((frame_data_o >> {dlc_o, 3'b000}) == 64'd0))
    else $error("payload bytes beyond dlc not cleared");

endmodule

bind periodic_can_frame_scheduler pcfs_checker u_pcfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .frame_valid_o (frame_valid_o),
  .can_id_o      (can_id_o),
  .dlc_o         (dlc_o),
  .frame_data_o  (frame_data_o)
);

`default_nettype wire

/* sim/periodic_can_frame_scheduler_tb.sv */
`default_nettype none

module periodic_can_frame_scheduler_tb;

  localparam logic [1:0] FuncSpare = 2'd3;
  localparam int SettleCycles = 150;
  localparam int QuietLimit = 2000;

  typedef struct packed {
    logic [1:0]  func;
    logic [17:0] pgn;
    logic [2:0]  prio;
    logic [7:0]  sa;
    logic [31:0] period;
    logic [3:0]  len;
    logic [63:0] payload;
    logic [31:0] last_sent;
    logic [31:0] now;
  } sched_word_t;

  typedef struct packed {
    logic [28:0] can_id;
    logic [3:0]  dlc;
    logic [63:0] data;
    logic        last;
  } frame_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  func_i = '0;
  logic [17:0] pgn_i = '0;
  logic [2:0]  priority_req_i = '0;
  logic [7:0]  source_address_i = '0;
  logic [31:0] period_ms_i = '0;
  logic [3:0]  data_length_i = '0;
  logic [63:0] payload_i = '0;
  logic [31:0] last_sent_ms_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        frame_valid_o;
  logic [28:0] can_id_o;
  logic [3:0]  dlc_o;
  logic [63:0] frame_data_o;
  logic        last_frame_o;

  periodic_can_frame_scheduler u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .func_i           (func_i),
    .pgn_i            (pgn_i),
    .priority_req_i   (priority_req_i),
    .source_address_i (source_address_i),
    .period_ms_i      (period_ms_i),
    .data_length_i    (data_length_i),
    .payload_i        (payload_i),
    .last_sent_ms_i   (last_sent_ms_i),
    .now_ms_i         (now_ms_i),
    .frame_valid_o    (frame_valid_o),
    .can_id_o         (can_id_o),
    .dlc_o            (dlc_o),
    .frame_data_o     (frame_data_o),
    .last_frame_o     (last_frame_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // scheduler mirror
  bit                 tx_enable = 1'b0;
  int                 tbl_count = 0;
  logic [31:0]        clock_now = '0;
  pcfs_pkg::entry_t   tbl [pcfs_pkg::MaxEntries];
  logic [31:0]        tbl_last [pcfs_pkg::MaxEntries];

  sched_word_t words_to_send [$];
  frame_t      frames_due [$];
  int          mismatches = 0;

  // generator-side view of the table, used only to shape stimulus
  logic [17:0] known_pgns [$];
  int          adds_queued = 0;
  logic [31:0] gen_now = '0;

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // returns 1 when entry i actually goes out as a frame
  function automatic bit entry_frame(int i, output frame_t f);
    logic [7:0]  pf;
    logic [7:0]  ps;
    logic [63:0] mask;
    pf = tbl[i].pgn[15:8];
    ps = (pf >= pcfs_pkg::Pdu2Threshold) ? tbl[i].pgn[7:0] : tbl[i].sa;
    f.can_id = {tbl[i].prio, 2'b00, pf, ps, tbl[i].sa};
    f.dlc = tbl[i].len;
    mask = (tbl[i].len >= pcfs_pkg::MaxDlc) ? '1 : ((64'd1 << (8 * tbl[i].len)) - 64'd1);
    f.data = tbl[i].payload & mask;
    f.last = 1'b0;
    return tx_enable && (tbl[i].len <= pcfs_pkg::MaxDlc);
  endfunction

  function automatic void advance_schedule(sched_word_t w);
    frame_t      burst [$];
    frame_t      f;
    logic [31:0] elapsed;
    case (w.func)
      pcfs_pkg::FUNC_ADD: begin
        if (tbl_count < pcfs_pkg::MaxEntries) begin
          tbl[tbl_count].pgn = w.pgn;
          tbl[tbl_count].prio = w.prio;
          tbl[tbl_count].sa = w.sa;
          tbl[tbl_count].period = w.period;
          tbl[tbl_count].len = w.len;
          tbl[tbl_count].payload = w.payload;
          tbl_last[tbl_count] = w.last_sent;
          tbl_count++;
        end
      end
      pcfs_pkg::FUNC_TICK: begin
        clock_now = w.now;
        for (int i = 0; i < tbl_count; i++) begin
          elapsed = clock_now - tbl_last[i];
          if (elapsed >= tbl[i].period) begin
            if (entry_frame(i, f)) burst.push_back(f);
            // stamp even when suppressed
            tbl_last[i] = clock_now;
          end
        end
      end
      pcfs_pkg::FUNC_SEND: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl[i].pgn == w.pgn) begin
            if (entry_frame(i, f)) burst.push_back(f);
            tbl_last[i] = clock_now;
            break;
          end
        end
      end
      default: ;
    endcase
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[k]) frames_due.push_back(burst[k]);
  endfunction

  // every field random; callers override what matters
  function automatic sched_word_t random_word();
    sched_word_t w;
    int          sel;
    w.func = 2'($urandom_range(0, 3));
    w.pgn = 18'($urandom);
    w.prio = 3'($urandom);
    w.sa = 8'($urandom);
    w.period = $urandom;
    w.len = 4'($urandom);
    w.payload = {$urandom, $urandom};
    w.last_sent = $urandom;
    w.now = $urandom;
    if ($urandom_range(0, 99) < ((adds_queued < pcfs_pkg::MaxEntries) ? 40 : 6)) begin
      w.func = pcfs_pkg::FUNC_ADD;
      sel = $urandom_range(0, 99);
      if (sel < 25) w.pgn[15:8] = 8'($urandom_range(240, 255));
      else if (sel < 50 && known_pgns.size() > 0)
        w.pgn = known_pgns[$urandom_range(0, known_pgns.size() - 1)];
      sel = $urandom_range(0, 99);
      if (sel < 70) w.period = $urandom_range(0, 40);
      else if (sel < 90) w.period = $urandom_range(0, 500);
      if ($urandom_range(0, 99) < 80) w.len = 4'($urandom_range(0, 8));
      if ($urandom_range(0, 99) < 70) w.last_sent = gen_now - $urandom_range(0, 60);
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        w.func = pcfs_pkg::FUNC_TICK;
        sel = $urandom_range(0, 99);
        if (sel < 80) w.now = gen_now + $urandom_range(1, 25);
        else if (sel < 90) w.now = gen_now;
      end else if (sel < 95) begin
        w.func = pcfs_pkg::FUNC_SEND;
        if ($urandom_range(0, 99) < 80 && known_pgns.size() > 0)
          w.pgn = known_pgns[$urandom_range(0, known_pgns.size() - 1)];
      end else begin
        w.func = FuncSpare;
      end
    end
    return w;
  endfunction

  // queues a word; returns 0 when the block will just ignore it
  function automatic bit post_word(sched_word_t w);
    words_to_send.push_back(w);
    if (w.func == pcfs_pkg::FUNC_ADD) begin
      if (adds_queued >= pcfs_pkg::MaxEntries) return 1'b0;
      known_pgns.push_back(w.pgn);
      adds_queued++;
    end else if (w.func == pcfs_pkg::FUNC_TICK) begin
      gen_now = w.now;
    end
    return w.func != FuncSpare;
  endfunction

  task automatic push_op(logic [1:0] func, logic [17:0] pgn, logic [31:0] now);
    sched_word_t w;
    w = random_word();
    w.func = func;
    w.pgn = pgn;
    w.now = now;
    void'(post_word(w));
  endtask

  task automatic push_add(logic [17:0] pgn, logic [2:0] prio, logic [7:0] sa,
                          logic [31:0] period, logic [3:0] len, logic [63:0] payload,
                          logic [31:0] last_sent);
    sched_word_t w;
    w = random_word();
    w.func = pcfs_pkg::FUNC_ADD;
    w.pgn = pgn;
    w.prio = prio;
    w.sa = sa;
    w.period = period;
    w.len = len;
    w.payload = payload;
    w.last_sent = last_sent;
    void'(post_word(w));
  endtask

  task automatic run_random(int count);
    int counted;
    counted = 0;
    while (counted < count) begin
      if (post_word(random_word())) counted++;
    end
  endtask

  task automatic wait_drained();
    while (words_to_send.size() != 0 || start_i || frames_due.size() != 0)
      @(posedge clk_i);
    // words that emit nothing may still be in the engine
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_tx_enable(bit value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    tx_enable = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // driver: bursts of words with random gaps
  sched_word_t cur_word;
  int          burst_left = 0;
  int          gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni && !(start_i && busy_o)) begin
      if (start_i) advance_schedule(cur_word);
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (words_to_send.size() > 0) begin
        cur_word = words_to_send.pop_front();
        func_i <= cur_word.func;
        pgn_i <= cur_word.pgn;
        priority_req_i <= cur_word.prio;
        source_address_i <= cur_word.sa;
        period_ms_i <= cur_word.period;
        data_length_i <= cur_word.len;
        payload_i <= cur_word.payload;
        last_sent_ms_i <= cur_word.last_sent;
        now_ms_i <= cur_word.now;
        start_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    frame_t want;
    if (rst_ni && frame_valid_o) begin
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("unexpected frame id %h", can_id_o));
      end else begin
        want = frames_due.pop_front();
        if (can_id_o !== want.can_id)
          report_mismatch($sformatf("can_id got %h want %h", can_id_o, want.can_id));
        if (dlc_o !== want.dlc)
          report_mismatch($sformatf("dlc got %h want %h", dlc_o, want.dlc));
        if (frame_data_o !== want.data)
          report_mismatch($sformatf("frame_data got %h want %h", frame_data_o, want.data));
        if (last_frame_o !== want.last)
          report_mismatch($sformatf("last_frame got %b want %b", last_frame_o, want.last));
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || frame_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table, transmit off
    write_tx_enable(1'b0);
    push_op(pcfs_pkg::FUNC_TICK, '0, '0);
    push_op(pcfs_pkg::FUNC_SEND, '0, '0);
    push_op(FuncSpare, 18'($urandom), $urandom);
    wait_drained();

    write_tx_enable(1'b1);
    push_add(18'h00000, 3'd0, 8'h00, 32'd0, 4'd0, '1, 32'd0);
    push_add(18'h3FFFF, 3'd7, 8'hFF, 32'hFFFF_FFFF, 4'd8, '1, 32'd1);
    push_add(18'h0F0AB, 3'd3, 8'h5A, 32'd10, 4'd8, {$urandom, $urandom}, 32'd0);
    push_add(18'h0EFCD, 3'd6, 8'hA5, 32'd10, 4'd5, {$urandom, $urandom}, 32'd0);
    push_add(18'h0EFCD, 3'd2, 8'h11, 32'd5, 4'd9, {$urandom, $urandom}, 32'd0);
    push_add(18'h1FF12, 3'd5, 8'h80, 32'd1, 4'd15, {$urandom, $urandom}, 32'd0);
    // period of all ones fires only when elapsed wraps to all ones
    push_op(pcfs_pkg::FUNC_TICK, 18'($urandom), 32'd0);
    push_op(pcfs_pkg::FUNC_TICK, 18'($urandom), 32'd10);
    push_op(pcfs_pkg::FUNC_TICK, 18'($urandom), 32'd10);
    // duplicate PGN: first match only
    push_op(pcfs_pkg::FUNC_SEND, 18'h0EFCD, $urandom);
    push_op(pcfs_pkg::FUNC_SEND, 18'h1FF12, $urandom);
    push_op(pcfs_pkg::FUNC_SEND, 18'h12345, $urandom);
    push_op(pcfs_pkg::FUNC_TICK, 18'($urandom), 32'hFFFF_FFF0);
    push_op(pcfs_pkg::FUNC_TICK, 18'($urandom), 32'd5);
    push_op(pcfs_pkg::FUNC_SEND, 18'h3FFFF, $urandom);
    push_op(FuncSpare, 18'($urandom), $urandom);
    wait_drained();

    run_random(210);
    wait_drained();

    write_tx_enable(1'b0);
    run_random(60);
    wait_drained();

    write_tx_enable(1'b1);
    run_random(125);
    wait_drained();

    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hdl/pcfs_pkg.sv
hdl/pcfs_front.sv
hdl/pcfs_back.sv
hdl/periodic_can_frame_scheduler.sv
hdl/pcfs_checker.sv
sim/periodic_can_frame_scheduler_tb.sv
